FILE: rtl/rms_peak_clip_monitor_defines.svh
// Assertion macros used by the level meter top level.
`ifndef RMS_PEAK_CLIP_MONITOR_DEFINES_SVH
`define RMS_PEAK_CLIP_MONITOR_DEFINES_SVH

// Checks a condition that must hold in the same cycle as its trigger.
`define RPCM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks a condition that must hold in the cycle after its trigger.
`define RPCM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/rpcm_pkg.sv
// Package with the types, constants and helpers of the level meter.
package rpcm_pkg;

    localparam int SAMPLE_BITS        = 16;
    localparam int CHANNELS_DEFAULT   = 2;
    localparam int MAX_BLOCK_DEFAULT  = 4096;

    localparam int PEAK_W  = SAMPLE_BITS - 1;
    localparam int SQ_W    = 2 * SAMPLE_BITS - 1;
    localparam int ROOT_W  = SAMPLE_BITS;
    localparam int RAD_W   = 2 * ROOT_W;
    localparam int CREST_W = 4;
    localparam int PROD_W  = CREST_W + ROOT_W;
    localparam int STEP_W  = $clog2(SQ_W);

    // Configuration register map.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = PEAK_W;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_THRESHOLD       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SATURATION_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CREST_RATIO          = 2'd2;

    localparam logic [PEAK_W-1:0]  CLIP_THRESHOLD_RESET       = 15'd32604;
    localparam logic [PEAK_W-1:0]  SATURATION_THRESHOLD_RESET = 15'd16384;
    localparam logic [CREST_W-1:0] CREST_RATIO_RESET          = 4'd4;

    typedef struct packed {
        logic                          channel;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          block_end;
    } in_item_t;

    typedef struct packed {
        logic              out_channel;
        logic [ROOT_W-1:0] rms_level;
        logic [PEAK_W-1:0] peak_level;
        logic              clip_flag;
        logic              oversaturation_flag;
    } out_item_t;

    typedef struct packed {
        logic load_item;
        logic square;
        logic accumulate;
        logic div_step;
        logic root_load;
        logic root_step;
        logic crest;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic chan_ok;
        logic block_end;
        logic out_free;
    } dp_status_t;

    // Bits needed to hold a sample count from 0 up to max_block.
    function automatic int count_width(input int max_block);
        return $clog2(max_block + 1);
    endfunction

endpackage

FILE: rtl/rpcm_ctrl.sv
// Controller state machine of the level meter.
module rpcm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    input  rpcm_pkg::dp_status_t status,
    output logic                 sample_ready,
    output rpcm_pkg::ctrl_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_SQUARE    = 3'd1;
    localparam logic [2:0] S_ACCUM     = 3'd2;
    localparam logic [2:0] S_DIVIDE    = 3'd3;
    localparam logic [2:0] S_ROOT_LOAD = 3'd4;
    localparam logic [2:0] S_ROOT      = 3'd5;
    localparam logic [2:0] S_CREST     = 3'd6;
    localparam logic [2:0] S_EMIT      = 3'd7;

    logic [2:0]                  state_reg;
    logic [2:0]                  state_next;
    logic [rpcm_pkg::STEP_W-1:0] step_reg;
    logic [rpcm_pkg::STEP_W-1:0] step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        cmd          = '0;
        sample_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                sample_ready  = 1'b1;
                cmd.load_item = sample_valid;
                if (sample_valid)
                begin
                    state_next = S_SQUARE;
                end
            end
            S_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = status.chan_ok ? S_ACCUM : S_IDLE;
            end
            S_ACCUM:
            begin
                cmd.accumulate = 1'b1;
                step_next      = rpcm_pkg::STEP_W'(rpcm_pkg::SQ_W - 1);
                state_next     = status.block_end ? S_DIVIDE : S_IDLE;
            end
            S_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == '0)
                begin
                    state_next = S_ROOT_LOAD;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            S_ROOT_LOAD:
            begin
                cmd.root_load = 1'b1;
                step_next     = rpcm_pkg::STEP_W'(rpcm_pkg::ROOT_W - 1);
                state_next    = S_ROOT;
            end
            S_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (step_reg == '0)
                begin
                    state_next = S_CREST;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            S_CREST:
            begin
                cmd.crest  = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // Hold here until the output register can take the result.
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/rpcm_datapath.sv
// Datapath of the level meter: channel state, divider, square root and result register.
module rpcm_datapath #(
    parameter int CHANNELS  = rpcm_pkg::CHANNELS_DEFAULT,
    parameter int MAX_BLOCK = rpcm_pkg::MAX_BLOCK_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rpcm_pkg::ctrl_cmd_t            cmd,
    output rpcm_pkg::dp_status_t           status,
    input  rpcm_pkg::in_item_t             sample_item,
    input  logic [rpcm_pkg::PEAK_W-1:0]    clip_threshold,
    input  logic [rpcm_pkg::PEAK_W-1:0]    saturation_threshold,
    input  logic [rpcm_pkg::CREST_W-1:0]   crest_ratio,
    input  logic                           result_ready,
    output logic                           result_valid,
    output rpcm_pkg::out_item_t            result_item
);

    localparam int SB     = rpcm_pkg::SAMPLE_BITS;
    localparam int SQ_W   = rpcm_pkg::SQ_W;
    localparam int ROOT_W = rpcm_pkg::ROOT_W;
    localparam int RAD_W  = rpcm_pkg::RAD_W;
    localparam int PEAK_W = rpcm_pkg::PEAK_W;
    localparam int PROD_W = rpcm_pkg::PROD_W;
    localparam int CNT_W  = rpcm_pkg::count_width(MAX_BLOCK);
    localparam int SUM_W  = CNT_W + SQ_W - 1;
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    rpcm_pkg::in_item_t  item_reg;
    logic [SQ_W-1:0]     sq_reg;
    logic [SUM_W-1:0]    sum_reg  [CHANNELS];
    logic [CNT_W-1:0]    cnt_reg  [CHANNELS];
    logic [PEAK_W-1:0]   peak_reg [CHANNELS];

    logic [CNT_W-1:0]    rem_reg;
    logic [SQ_W-1:0]     quo_reg;
    logic [CNT_W-1:0]    divisor_reg;
    logic [RAD_W-1:0]    rad_reg;
    logic [ROOT_W+1:0]   srem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [PEAK_W-1:0]   peak_res_reg;
    logic                chan_res_reg;
    logic [PROD_W-1:0]   prod_reg;
    rpcm_pkg::out_item_t result_item_reg;
    logic                result_valid_reg;

    logic [CH_W-1:0]     ch_idx;
    logic [SB-1:0]       mag;
    logic [2*SB-1:0]     sq_full;
    logic                room;
    logic [SUM_W-1:0]    sum_upd;
    logic [CNT_W-1:0]    cnt_upd;
    logic [PEAK_W-1:0]   peak_upd;
    logic [SUM_W-1:0]    sum_next;
    logic [CNT_W-1:0]    cnt_next;
    logic [PEAK_W-1:0]   peak_next;

    logic [CNT_W:0]      div_trial;
    logic                div_ge;
    logic [CNT_W-1:0]    rem_next;
    logic [SQ_W-1:0]     quo_next;

    logic [ROOT_W+3:0]   root_shift;
    logic [ROOT_W+3:0]   root_trial;
    logic                root_ge;
    logic [ROOT_W+1:0]   srem_next;
    logic [ROOT_W-1:0]   root_next;

    assign ch_idx  = CH_W'(item_reg.channel);
    assign mag     = item_reg.sample[SB-1] ? (~$unsigned(item_reg.sample) + 1'b1)
                                           : $unsigned(item_reg.sample);
    assign sq_full = mag * mag;

    // Per-channel update; sum and count stop once the block reaches its limit.
    always_comb
    begin
        room      = cnt_reg[ch_idx] < CNT_W'(MAX_BLOCK);
        sum_upd   = room ? (sum_reg[ch_idx] + SUM_W'(sq_reg)) : sum_reg[ch_idx];
        cnt_upd   = room ? (cnt_reg[ch_idx] + 1'b1) : cnt_reg[ch_idx];
        peak_upd  = (!item_reg.sample[SB-1] && (mag[PEAK_W-1:0] > peak_reg[ch_idx]))
                    ? mag[PEAK_W-1:0] : peak_reg[ch_idx];
        sum_next  = item_reg.block_end ? '0 : sum_upd;
        cnt_next  = item_reg.block_end ? '0 : cnt_upd;
        peak_next = item_reg.block_end ? '0 : peak_upd;
    end

    // Restoring division, one quotient bit per step.
    always_comb
    begin
        div_trial = {rem_reg, quo_reg[SQ_W-1]};
        div_ge    = div_trial >= {1'b0, divisor_reg};
        rem_next  = div_ge ? CNT_W'(div_trial - {1'b0, divisor_reg}) : div_trial[CNT_W-1:0];
        quo_next  = {quo_reg[SQ_W-2:0], div_ge};
    end

    // Digit-by-digit square root, one root bit per step.
    always_comb
    begin
        root_shift = {srem_reg, rad_reg[RAD_W-1 -: 2]};
        root_trial = {2'b00, root_reg, 2'b01};
        root_ge    = root_shift >= root_trial;
        srem_next  = root_ge ? (ROOT_W+2)'(root_shift - root_trial)
                             : root_shift[ROOT_W+1:0];
        root_next  = {root_reg[ROOT_W-2:0], root_ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                sum_reg[i]  <= '0;
                cnt_reg[i]  <= '0;
                peak_reg[i] <= '0;
            end
        end
        else if (cmd.accumulate)
        begin
            sum_reg[ch_idx]  <= sum_next;
            cnt_reg[ch_idx]  <= cnt_next;
            peak_reg[ch_idx] <= peak_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= sample_item;
        end
        if (cmd.square)
        begin
            sq_reg <= sq_full[SQ_W-1:0];
        end
        if (cmd.accumulate)
        begin
            // The quotient fits SQ_W bits, so the high part starts below the divisor.
            rem_reg      <= CNT_W'(sum_upd >> SQ_W);
            quo_reg      <= sum_upd[SQ_W-1:0];
            divisor_reg  <= cnt_upd;
            peak_res_reg <= peak_upd;
            chan_res_reg <= item_reg.channel;
        end
        if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
        if (cmd.root_load)
        begin
            rad_reg  <= RAD_W'(quo_reg);
            srem_reg <= '0;
            root_reg <= '0;
        end
        if (cmd.root_step)
        begin
            rad_reg  <= rad_reg << 2;
            srem_reg <= srem_next;
            root_reg <= root_next;
        end
        if (cmd.crest)
        begin
            prod_reg <= PROD_W'(crest_ratio) * PROD_W'(root_reg);
        end
        if (cmd.emit)
        begin
            result_item_reg.out_channel         <= chan_res_reg;
            result_item_reg.rms_level           <= root_reg;
            result_item_reg.peak_level          <= peak_res_reg;
            result_item_reg.clip_flag           <= peak_res_reg > clip_threshold;
            result_item_reg.oversaturation_flag <= (peak_res_reg > saturation_threshold)
                                                   && (PROD_W'(peak_res_reg) > prod_reg);
        end
    end

    assign status.chan_ok   = int'(item_reg.channel) < CHANNELS;
    assign status.block_end = item_reg.block_end;
    assign status.out_free  = !result_valid_reg || result_ready;

    assign result_valid = result_valid_reg;
    assign result_item  = result_item_reg;

endmodule

FILE: rtl/rms_peak_clip_monitor.sv
// Top level of the RMS, peak and clip level meter.
//
// The meter takes Q1.15 samples tagged with a channel and an end-of-block mark, and keeps
// for each channel a sum of squares, a positive running peak (a signed maximum starting at
// zero) and a sample count; sum and count stop growing once a block reaches MAX_BLOCK
// samples, while the peak keeps tracking. The sample that carries block_end is folded in
// first, then one result is reported: the RMS as the floor square root of the floor mean
// square, the peak, a clip flag (peak above clip_threshold) and an oversaturation flag
// (peak above saturation_threshold and above crest_ratio times the RMS); the channel then
// starts a fresh block. Samples on a channel at or above CHANNELS are dropped. The block
// works on one sample at a time. An ordinary sample goes through the square and
// accumulate steps before sample_ready is high again (a dropped one skips accumulate);
// a block-end sample then also goes through the divide, root load, root, crest and emit
// steps. The mean comes from a restoring divider that yields one quotient bit per cycle,
// the RMS from a digit-by-digit square root unit that yields one bit per cycle. Results
// sit in an output register, so new samples are taken while a result waits for its
// transfer; the next block-end sample is taken too, but the meter then holds in its emit
// step until that result has gone. Configuration is written through cfg_wr_en, cfg_index
// and cfg_wdata and should be changed only while the meter is idle.
`include "rms_peak_clip_monitor_defines.svh"

module rms_peak_clip_monitor #(
    parameter int CHANNELS  = rpcm_pkg::CHANNELS_DEFAULT,
    parameter int MAX_BLOCK = rpcm_pkg::MAX_BLOCK_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               sample_valid,
    output logic                               sample_ready,
    input  rpcm_pkg::in_item_t                 sample_item,

    output logic                               result_valid,
    input  logic                               result_ready,
    output rpcm_pkg::out_item_t                result_item,

    input  logic                               cfg_wr_en,
    input  logic [rpcm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rpcm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    logic [rpcm_pkg::PEAK_W-1:0]  clip_threshold_reg;
    logic [rpcm_pkg::PEAK_W-1:0]  saturation_threshold_reg;
    logic [rpcm_pkg::CREST_W-1:0] crest_ratio_reg;

    rpcm_pkg::ctrl_cmd_t  ctrl_cmd;
    rpcm_pkg::dp_status_t dp_status;

    // Configuration registers; writes to an unused index are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_threshold_reg       <= rpcm_pkg::CLIP_THRESHOLD_RESET;
            saturation_threshold_reg <= rpcm_pkg::SATURATION_THRESHOLD_RESET;
            crest_ratio_reg          <= rpcm_pkg::CREST_RATIO_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                rpcm_pkg::CFG_CLIP_THRESHOLD:
                begin
                    clip_threshold_reg <= cfg_wdata;
                end
                rpcm_pkg::CFG_SATURATION_THRESHOLD:
                begin
                    saturation_threshold_reg <= cfg_wdata;
                end
                rpcm_pkg::CFG_CREST_RATIO:
                begin
                    crest_ratio_reg <= cfg_wdata[rpcm_pkg::CREST_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // The controller sequences each sample through the datapath steps.
    rpcm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .status       (dp_status),
        .sample_ready (sample_ready),
        .cmd          (ctrl_cmd)
    );

    // The datapath holds the per-channel state and the arithmetic units.
    rpcm_datapath #(
        .CHANNELS  (CHANNELS),
        .MAX_BLOCK (MAX_BLOCK)
    ) u_datapath (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (ctrl_cmd),
        .status               (dp_status),
        .sample_item          (sample_item),
        .clip_threshold       (clip_threshold_reg),
        .saturation_threshold (saturation_threshold_reg),
        .crest_ratio          (crest_ratio_reg),
        .result_ready         (result_ready),
        .result_valid         (result_valid),
        .result_item          (result_item)
    );

    // A new result must never overwrite one that has not completed its transfer.
    `RPCM_ASSERT_SAME(a_emit_needs_free, ctrl_cmd.emit, dp_status.out_free, "result overwritten")
    // No sample is taken while the divider or square root unit is running.
    `RPCM_ASSERT_SAME(a_ready_only_idle, sample_ready, !(ctrl_cmd.div_step || ctrl_cmd.root_step), "ready while busy")
    // Every result that appears was produced by the controller's emit step.
    `RPCM_ASSERT_SAME(a_result_from_emit, $rose(result_valid), $past(ctrl_cmd.emit), "result without emit")
    // In the cycle after a sample transfer the meter is busy.
    `RPCM_ASSERT_NEXT(a_busy_after_take, sample_valid && sample_ready, !sample_ready, "ready right after transfer")

endmodule

FILE: sim/rpcm_level_check.sv
`timescale 1ns / 1ps
// Scoreboard that predicts the level meter's block reports and checks every result transfer.
module rpcm_level_check #(
    parameter int CHANNELS  = rpcm_pkg::CHANNELS_DEFAULT,
    parameter int MAX_BLOCK = rpcm_pkg::MAX_BLOCK_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            sample_valid,
    input  logic                            sample_ready,
    input  rpcm_pkg::in_item_t              sample_item,
    input  logic                            result_valid,
    input  logic                            result_ready,
    input  rpcm_pkg::out_item_t             result_item,
    input  logic                            cfg_wr_en,
    input  logic [rpcm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rpcm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                              fail_count,
    output int                              outstanding
);
    import rpcm_pkg::*;

    localparam int REPORT_LIMIT = 10;

    logic [PEAK_W-1:0]  clip_level;
    logic [PEAK_W-1:0]  sat_level;
    logic [CREST_W-1:0] crest;

    longint unsigned    energy [CHANNELS];
    int                 top_sample [CHANNELS];
    int                 fill [CHANNELS];

    out_item_t          pending_reports [$];
    int                 errors = 0;

    function automatic logic [ROOT_W-1:0] floor_root(input longint unsigned v);
        longint unsigned r;
        longint unsigned trial;
        r = 0;
        for (int b = ROOT_W; b >= 0; b--)
        begin
            trial = r | (64'd1 << b);
            if (trial * trial <= v)
                r = trial;
        end
        return r[ROOT_W-1:0];
    endfunction

    // Folds one sample into its channel and, on a block end, queues the report it must produce.
    task automatic fold_sample(input in_item_t it);
        int              ch;
        int              level;
        int              mag;
        longint unsigned n;
        out_item_t       rep;
        ch    = int'(it.channel);
        level = int'($signed(it.sample));
        if (ch >= CHANNELS)
            return;
        mag = (level < 0) ? -level : level;
        if (fill[ch] < MAX_BLOCK)
        begin
            energy[ch] += mag * mag;
            fill[ch]++;
        end
        if (level > top_sample[ch])
            top_sample[ch] = level;
        if (!it.block_end)
            return;
        n = fill[ch];
        rep.out_channel         = it.channel;
        rep.rms_level           = floor_root(energy[ch] / n);
        rep.peak_level          = PEAK_W'(top_sample[ch]);
        rep.clip_flag           = top_sample[ch] > int'(clip_level);
        rep.oversaturation_flag = (top_sample[ch] > int'(sat_level)) &&
                                  (top_sample[ch] > int'(crest) * int'(rep.rms_level));
        pending_reports.push_back(rep);
        energy[ch]     = 0;
        top_sample[ch] = 0;
        fill[ch]       = 0;
    endtask

    task automatic compare_report(input out_item_t got);
        out_item_t want;
        if (pending_reports.size() == 0)
        begin
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("[%0t] unexpected result: ch %0d rms %0d peak %0d clip %0b over %0b",
                         $time, got.out_channel, got.rms_level, got.peak_level,
                         got.clip_flag, got.oversaturation_flag);
            return;
        end
        want = pending_reports.pop_front();
        if (got.out_channel !== want.out_channel || got.rms_level !== want.rms_level ||
            got.peak_level !== want.peak_level || got.clip_flag !== want.clip_flag ||
            got.oversaturation_flag !== want.oversaturation_flag)
        begin
            errors++;
            if (errors <= REPORT_LIMIT)
                $display({"[%0t] result mismatch: expected ch %0d rms %0d peak %0d clip %0b",
                          " over %0b, got ch %0d rms %0d peak %0d clip %0b over %0b"},
                         $time, want.out_channel, want.rms_level, want.peak_level,
                         want.clip_flag, want.oversaturation_flag, got.out_channel,
                         got.rms_level, got.peak_level, got.clip_flag,
                         got.oversaturation_flag);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_level = CLIP_THRESHOLD_RESET;
            sat_level  = SATURATION_THRESHOLD_RESET;
            crest      = CREST_RATIO_RESET;
            for (int c = 0; c < CHANNELS; c++)
            begin
                energy[c]     = 0;
                top_sample[c] = 0;
                fill[c]       = 0;
            end
            pending_reports.delete();
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_CLIP_THRESHOLD:       clip_level = cfg_wdata[PEAK_W-1:0];
                    CFG_SATURATION_THRESHOLD: sat_level  = cfg_wdata[PEAK_W-1:0];
                    CFG_CREST_RATIO:          crest      = cfg_wdata[CREST_W-1:0];
                    default: ;
                endcase
            end
            if (result_valid && result_ready)
                compare_report(result_item);
            if (sample_valid && sample_ready)
                fold_sample(sample_item);
        end
        fail_count  <= errors;
        outstanding <= pending_reports.size();
    end

endmodule

FILE: sim/tb_rms_peak_clip_monitor.sv
`timescale 1ns / 1ps
// Testbench top for the level meter: sample stimulus, configuration, back-pressure, verdict.
module tb_rms_peak_clip_monitor;
    import rpcm_pkg::*;

    localparam int CHANNELS      = CHANNELS_DEFAULT;
    localparam int MAX_BLOCK     = MAX_BLOCK_DEFAULT;
    // Wait margin for a block-end sample before its result is registered.
    localparam int BUSY_CYCLES   = 3 * SAMPLE_BITS + 5;
    localparam int SETTLE_CYCLES = BUSY_CYCLES + 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int IDLE_PCT      = 26;
    localparam int CYCLE_LIMIT   = 250_000;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  sample_valid = 1'b0;
    logic                  sample_ready;
    in_item_t              sample_item  = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    out_item_t             result_item;
    logic                  cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = CFG_CLIP_THRESHOLD;
    logic [CFG_DATA_W-1:0] cfg_wdata    = '0;

    int fail_count;
    int outstanding;
    // While quiet is set neither the sender nor the receiver inserts idle cycles.
    bit quiet     = 1'b0;
    // Each increment asks the receiver for one long hold-off.
    int hold_asks = 0;
    int cycles    = 0;

    rms_peak_clip_monitor #(
        .CHANNELS  (CHANNELS),
        .MAX_BLOCK (MAX_BLOCK)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_item  (sample_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    rpcm_level_check #(
        .CHANNELS  (CHANNELS),
        .MAX_BLOCK (MAX_BLOCK)
    ) u_level_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_item  (sample_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("rms_peak_clip_monitor verification failed");
            $finish;
        end
    end

    // Result side. Ready drops at random unless quiet is set. When a hold-off is asked for,
    // ready stays low for a hold-off counted here by HOLD_CYCLES, so that a result sits in the
    // output register and the next block-end sample backs up the sample channel.
    initial
    begin
        int served;
        served = 0;
        forever
        begin
            @(posedge clk);
            if (served < hold_asks)
            begin
                served++;
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                result_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Offers one sample and returns in the time step of its transfer. Valid is left high,
    // so the next call either presents a new payload or first drops valid while it waits idle.
    task automatic offer_sample(input bit ch, input int level, input bit last);
        in_item_t it;
        it.channel   = ch;
        it.sample    = SAMPLE_BITS'(level);
        it.block_end = last;
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_item  <= it;
        do
            @(posedge clk);
        while (!sample_ready);
    endtask

    // Stops the sample stream and waits until every expected report has been transferred,
    // then lets the meter finish any ordinary sample still in flight.
    task automatic settle();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all three registers on consecutive edges; only called while the meter is idle.
    task automatic apply_config(input int clip, input int sat, input int ratio);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_CLIP_THRESHOLD;
        cfg_wdata <= CFG_DATA_W'(clip);
        @(posedge clk);
        cfg_index <= CFG_SATURATION_THRESHOLD;
        cfg_wdata <= CFG_DATA_W'(sat);
        @(posedge clk);
        cfg_index <= CFG_CREST_RATIO;
        cfg_wdata <= CFG_DATA_W'(ratio);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Random samples on random channels with short blocks. A mix of full-scale values,
    // quiet passages and the range edges gives both small and large crest factors, so the
    // clip and oversaturation flags both toggle under most settings.
    task automatic random_traffic(input int n);
        int level;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(9))
                0:
                begin
                    case ($urandom_range(4))
                        0:       level = 32767;
                        1:       level = -32768;
                        2:       level = 0;
                        3:       level = 1;
                        default: level = -1;
                    endcase
                end
                1, 2, 3: level = int'($urandom_range(1023)) - 512;
                default: level = int'($urandom_range(65535)) - 32768;
            endcase
            offer_sample(1'($urandom_range(1)), level, $urandom_range(5) == 0);
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration. Both ends of the sample range in one block, a lone negative
        // full-scale sample (peak stays at zero while the RMS reaches 32768), an all-zero
        // block, and a peak right at and just above the clip threshold.
        offer_sample(0, 32767, 0);
        offer_sample(0, -32768, 0);
        offer_sample(0, 0, 1);
        offer_sample(1, -32768, 1);
        offer_sample(0, 0, 1);
        offer_sample(1, 32604, 1);
        offer_sample(1, 32605, 1);
        // Two channels with interleaved blocks must not disturb each other.
        offer_sample(0, 100, 0);
        offer_sample(1, -5, 0);
        offer_sample(0, -200, 0);
        offer_sample(1, 7, 1);
        offer_sample(0, 300, 1);
        offer_sample(0, 1, 1);
        offer_sample(1, -1, 1);

        // The receiver goes silent while block-end samples keep coming, so the output
        // register fills and the meter has to stall the sample channel.
        hold_asks = hold_asks + 1;
        for (int i = 0; i < 6; i++)
            offer_sample(1'(i % 2), int'($urandom_range(65535)) - 32768, 1);
        random_traffic(150);
        settle();

        // Thresholds and crest ratio at zero: with a zero RMS any positive peak flags
        // oversaturation. This phase also runs without any idle cycles on either side.
        apply_config(0, 0, 0);
        quiet = 1'b1;
        offer_sample(0, 1, 0);
        offer_sample(0, 0, 1);
        offer_sample(1, 0, 1);
        random_traffic(200);
        settle();
        quiet = 1'b0;

        // Thresholds at full scale: nothing can clip or oversaturate.
        apply_config(32767, 32767, 15);
        offer_sample(0, 32767, 1);
        random_traffic(150);
        settle();

        apply_config($urandom_range(32767), $urandom_range(32767), $urandom_range(15, 1));
        random_traffic(200);
        settle();

        // Low thresholds with a crest ratio of one, so oversaturation follows the RMS closely.
        apply_config(16000, 8000, 1);
        random_traffic(150);
        settle();

        apply_config(int'(CLIP_THRESHOLD_RESET), int'(SATURATION_THRESHOLD_RESET),
                     int'(CREST_RATIO_RESET));
        random_traffic(150);
        settle();

        if (fail_count == 0 && outstanding == 0)
            $display("rms_peak_clip_monitor verification clean");
        else
            $display("rms_peak_clip_monitor verification failed");
        $finish;
    end

endmodule
